// ===== src/rwc_pkg.sv =====
// ----------------------------------------------------------------------------
// rwc_pkg
// Shared types and constants of the row window write-back cache: request
// codes, register indexes, sizes, sequencer states and the status bundle.
// ----------------------------------------------------------------------------
package rwc_pkg;

	// request codes
	localparam logic [1:0] REQ_LOAD  = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_WRITE = 2'd2;
	localparam logic [1:0] REQ_RESET = 2'd3;

	// register indexes, taken from paddr[2]
	localparam logic REG_MATRIX_DIM   = 1'b0;
	localparam logic REG_WINDOW_WIDTH = 1'b1;

	// matrix and window sizes, tied to the field widths below
	localparam int unsigned DIM_MAX    = 64;
	localparam int unsigned WINDOW_MAX = 16;
	localparam int unsigned DIM_W      = $clog2(DIM_MAX + 1);
	localparam int unsigned CW         = $clog2(WINDOW_MAX + 1);

	// field and register widths
	localparam int unsigned PADDR_BITS  = 3;
	localparam int unsigned PDATA_BITS  = 32;
	localparam int unsigned MD_BITS     = 7;
	localparam int unsigned WW_BITS     = 5;
	localparam int unsigned POS_BITS    = 6;
	localparam int unsigned COUNT_BITS  = 32;

	localparam logic [MD_BITS-1:0] MD_RESET = 7'd64;
	localparam logic [WW_BITS-1:0] WW_RESET = 5'd4;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_WB,
		ST_FILL,
		ST_ACCESS,
		ST_READ_OUT
	} state_t;

	// status bundle from the sequencer
	typedef struct packed {
		state_t state;
		logic   wb_pend;
		logic   pipe_vld;
	} seq_status_t;

endpackage

// ===== src/rwc_ram.sv =====
// ----------------------------------------------------------------------------
// rwc_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rwc_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== src/rwc_regs.sv =====
// ----------------------------------------------------------------------------
// rwc_regs
// APB register file holding matrix_dim and window_width, with the clamped
// working values and a write pulse that invalidates the window.
// ----------------------------------------------------------------------------
module rwc_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [rwc_pkg::PADDR_BITS-1:0]    paddr,
	input  logic [rwc_pkg::PDATA_BITS-1:0]    pwdata,
	output logic [rwc_pkg::PDATA_BITS-1:0]    prdata,
	output logic                              pready,
	output logic [rwc_pkg::DIM_W-1:0]         dim,
	output logic [rwc_pkg::CW-1:0]            width,
	output logic                              cfg_wr
);

	localparam int unsigned DIM_W = rwc_pkg::DIM_W;
	localparam int unsigned CW    = rwc_pkg::CW;
	localparam int unsigned DCW = (DIM_W > rwc_pkg::MD_BITS) ? DIM_W : rwc_pkg::MD_BITS;
	localparam int unsigned WCW = (CW > rwc_pkg::WW_BITS) ? CW : rwc_pkg::WW_BITS;

	logic [rwc_pkg::MD_BITS-1:0] matrix_dim_q;
	logic [rwc_pkg::WW_BITS-1:0] window_width_q;
	logic [DCW-1:0]              md_ext;
	logic [WCW-1:0]              ww_ext;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_dim_q   <= rwc_pkg::MD_RESET;
			window_width_q <= rwc_pkg::WW_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				rwc_pkg::REG_MATRIX_DIM:   matrix_dim_q   <= pwdata[rwc_pkg::MD_BITS-1:0];
				rwc_pkg::REG_WINDOW_WIDTH: window_width_q <= pwdata[rwc_pkg::WW_BITS-1:0];
				default: ;
			endcase
		end
	end

	// read-back mux
	always_comb begin
		unique case (paddr[2])
			rwc_pkg::REG_MATRIX_DIM:   prdata = rwc_pkg::PDATA_BITS'(matrix_dim_q);
			rwc_pkg::REG_WINDOW_WIDTH: prdata = rwc_pkg::PDATA_BITS'(window_width_q);
			default:                   prdata = '0;
		endcase
	end

	// clamp the dimension to [1, DIM_MAX]
	always_comb begin
		md_ext = DCW'(matrix_dim_q);
		if (md_ext == '0) begin
			dim = DIM_W'(1);
		end else if (md_ext > DCW'(rwc_pkg::DIM_MAX)) begin
			dim = DIM_W'(rwc_pkg::DIM_MAX);
		end else begin
			dim = DIM_W'(md_ext);
		end
	end

	// clamp the window width to [1, WINDOW_MAX]
	always_comb begin
		ww_ext = WCW'(window_width_q);
		if (ww_ext == '0) begin
			width = CW'(1);
		end else if (ww_ext > WCW'(rwc_pkg::WINDOW_MAX)) begin
			width = CW'(rwc_pkg::WINDOW_MAX);
		end else begin
			width = CW'(ww_ext);
		end
	end

endmodule

// ===== src/rwc_seq.sv =====
// ----------------------------------------------------------------------------
// rwc_seq
// Request sequencer around the backing store and window buffer memories:
// lookup, write-back sweep, refill sweep and result register.
// ----------------------------------------------------------------------------
module rwc_seq #(
	parameter int unsigned DATA_BITS  = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        req_type,
	input  logic [rwc_pkg::POS_BITS-1:0]      row,
	input  logic [rwc_pkg::POS_BITS-1:0]      col,
	input  logic [DATA_BITS-1:0]              value,
	input  logic [rwc_pkg::DIM_W-1:0]         dim,
	input  logic [rwc_pkg::CW-1:0]            width,
	input  logic                              cfg_wr,
	output logic                              done,
	output logic [DATA_BITS-1:0]              read_data,
	output logic                              hit,
	output logic [rwc_pkg::COUNT_BITS-1:0]    miss_count,
	output rwc_pkg::seq_status_t              status
);

	localparam int unsigned DIM_MAX    = rwc_pkg::DIM_MAX;
	localparam int unsigned WINDOW_MAX = rwc_pkg::WINDOW_MAX;
	localparam int unsigned DIM_W      = rwc_pkg::DIM_W;
	localparam int unsigned CW         = rwc_pkg::CW;
	localparam int unsigned AW  = (DIM_MAX > 1) ? $clog2(DIM_MAX * DIM_MAX) : 1;
	localparam int unsigned LW  = $clog2(DIM_MAX * DIM_MAX + WINDOW_MAX + 1);
	localparam int unsigned IW  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int unsigned RCW = (DIM_W > rwc_pkg::POS_BITS) ? DIM_W : rwc_pkg::POS_BITS;
	localparam int unsigned OCW = rwc_pkg::POS_BITS + 1;

	rwc_pkg::state_t state_q, state_n;

	// request registers
	logic [1:0]                   req_type_q;
	logic [rwc_pkg::POS_BITS-1:0] row_q;
	logic [rwc_pkg::POS_BITS-1:0] col_q;
	logic [DATA_BITS-1:0]         value_q;
	logic [LW-1:0]                addr_q;
	logic [LW-1:0]                limit_q;
	logic                         in_range_q;
	logic                         hit_q;

	// window tag and bookkeeping
	logic                         win_valid_q;
	logic                         win_dirty_q;
	logic [rwc_pkg::POS_BITS-1:0] win_row_q;
	logic [rwc_pkg::POS_BITS-1:0] win_col_q;
	logic [LW-1:0]                win_base_q;
	logic [CW-1:0]                win_cnt_q;
	logic [rwc_pkg::COUNT_BITS-1:0] fill_cnt_q;
	logic                         wb_pend_q;
	logic                         wb_only_q;

	// sweep counter and memory pipeline stage
	logic [CW-1:0]                idx_q;
	logic                         pipe_vld_s1;
	logic                         pipe_zero_s1;
	logic [IW-1:0]                pipe_idx_s1;

	// result register
	logic                         done_q;
	logic [DATA_BITS-1:0]         rdata_q;
	logic                         hit_out_q;
	logic [rwc_pkg::COUNT_BITS-1:0] miss_q;

	// memory ports
	logic                 st_we;
	logic [AW-1:0]        st_waddr;
	logic [DATA_BITS-1:0] st_wdata;
	logic [AW-1:0]        st_raddr;
	logic [DATA_BITS-1:0] st_rdata;
	logic                 wb_we;
	logic [IW-1:0]        wb_waddr;
	logic [DATA_BITS-1:0] wb_wdata;
	logic [IW-1:0]        wb_raddr;
	logic [DATA_BITS-1:0] wb_rdata;

	// decoded conditions
	logic                 accept;
	logic                 is_reset;
	logic                 is_load;
	logic                 is_read;
	logic                 need_wb;
	logic                 acc_hit;
	logic [OCW-1:0]       col_diff;
	logic [LW-1:0]        ld_off;
	logic                 ld_in_win;
	logic [LW-1:0]        sweep_addr;
	logic [LW-1:0]        base_new;
	logic [LW-1:0]        rem;
	logic                 wb_issue;
	logic                 fill_issue;
	logic                 wb_last;
	logic                 fill_last;
	logic                 fill_go;
	logic                 sweep_go;
	logic                 emit;
	logic [DATA_BITS-1:0] emit_rd;
	logic                 emit_hit;

	assign busy   = (state_q != rwc_pkg::ST_IDLE) || wb_pend_q;
	assign accept = start && !busy;

	assign is_reset = (req_type_q == rwc_pkg::REQ_RESET);
	assign is_load  = (req_type_q == rwc_pkg::REQ_LOAD);
	assign is_read  = (req_type_q == rwc_pkg::REQ_READ);
	assign need_wb  = win_valid_q && win_dirty_q;

	// window hit for reads and writes
	assign col_diff = OCW'(col_q) - OCW'(win_col_q);
	assign acc_hit  = win_valid_q && (row_q == win_row_q) && (col_q >= win_col_q)
		&& (col_diff < OCW'(width));

	// load landing inside the window
	assign ld_off    = addr_q - win_base_q;
	assign ld_in_win = win_valid_q && (addr_q >= win_base_q) && (ld_off < LW'(width));

	// sweep position and loop ends
	assign sweep_addr = win_base_q + LW'(idx_q);
	assign wb_issue   = (state_q == rwc_pkg::ST_WB) && (idx_q < win_cnt_q);
	assign fill_issue = (state_q == rwc_pkg::ST_FILL) && (idx_q < width);
	assign wb_last    = (idx_q == win_cnt_q) && !pipe_vld_s1;
	assign fill_last  = (idx_q == width) && !pipe_vld_s1;

	// new window position and in-range word count
	assign base_new = is_reset ? '0 : addr_q;
	assign rem      = limit_q - base_new;

	assign fill_go  = (state_n == rwc_pkg::ST_FILL) && (state_q != rwc_pkg::ST_FILL);
	assign sweep_go = fill_go || ((state_n == rwc_pkg::ST_WB) && (state_q != rwc_pkg::ST_WB));

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			rwc_pkg::ST_IDLE: begin
				if (wb_pend_q) begin
					state_n = rwc_pkg::ST_WB;
				end else if (start) begin
					state_n = rwc_pkg::ST_LOOKUP;
				end
			end
			rwc_pkg::ST_LOOKUP: begin
				if (is_reset) begin
					state_n = need_wb ? rwc_pkg::ST_WB : rwc_pkg::ST_FILL;
				end else if (!in_range_q || is_load) begin
					state_n = rwc_pkg::ST_IDLE;
				end else if (acc_hit) begin
					state_n = is_read ? rwc_pkg::ST_READ_OUT : rwc_pkg::ST_IDLE;
				end else begin
					state_n = need_wb ? rwc_pkg::ST_WB : rwc_pkg::ST_FILL;
				end
			end
			rwc_pkg::ST_WB: begin
				if (wb_last) begin
					state_n = wb_only_q ? rwc_pkg::ST_IDLE : rwc_pkg::ST_FILL;
				end
			end
			rwc_pkg::ST_FILL: begin
				if (fill_last) begin
					state_n = rwc_pkg::ST_ACCESS;
				end
			end
			rwc_pkg::ST_ACCESS: begin
				state_n = is_read ? rwc_pkg::ST_READ_OUT : rwc_pkg::ST_IDLE;
			end
			rwc_pkg::ST_READ_OUT: begin
				state_n = rwc_pkg::ST_IDLE;
			end
			default: state_n = rwc_pkg::ST_IDLE;
		endcase
	end

	// store address of a window word during the write-back sweep
	function automatic logic [AW-1:0] sweep_wb_addr(input logic [LW-1:0] base,
		input logic [IW-1:0] i);
		logic [LW-1:0] a;
		a = base + LW'(i);
		return a[AW-1:0];
	endfunction

	// memory controls and result strobe
	always_comb begin
		st_we    = 1'b0;
		st_waddr = addr_q[AW-1:0];
		st_wdata = value_q;
		st_raddr = sweep_addr[AW-1:0];
		wb_we    = 1'b0;
		wb_waddr = col_diff[IW-1:0];
		wb_wdata = value_q;
		wb_raddr = col_diff[IW-1:0];
		emit     = 1'b0;
		emit_rd  = '0;
		emit_hit = 1'b0;
		unique case (state_q)
			rwc_pkg::ST_LOOKUP: begin
				if (!is_reset) begin
					if (!in_range_q) begin
						emit = 1'b1;
					end else if (is_load) begin
						st_we    = 1'b1;
						wb_we    = ld_in_win;
						wb_waddr = ld_off[IW-1:0];
						emit     = 1'b1;
					end else if (acc_hit && !is_read) begin
						wb_we    = 1'b1;
						emit     = 1'b1;
						emit_hit = 1'b1;
					end
				end
			end
			rwc_pkg::ST_WB: begin
				// window word read ahead, store written in the cycle after
				wb_raddr = idx_q[IW-1:0];
				st_we    = pipe_vld_s1;
				st_waddr = sweep_wb_addr(win_base_q, pipe_idx_s1);
				st_wdata = wb_rdata;
			end
			rwc_pkg::ST_FILL: begin
				// store word read ahead, words past the end fill as zero
				wb_we    = pipe_vld_s1;
				wb_waddr = pipe_idx_s1;
				wb_wdata = pipe_zero_s1 ? '0 : st_rdata;
			end
			rwc_pkg::ST_ACCESS: begin
				// a fresh window starts at the requested word, or at word 0 after a reset
				wb_raddr = '0;
				wb_waddr = '0;
				if (is_reset) begin
					emit = 1'b1;
				end else if (!is_read) begin
					wb_we = 1'b1;
					emit  = 1'b1;
				end
			end
			rwc_pkg::ST_READ_OUT: begin
				emit     = 1'b1;
				emit_rd  = wb_rdata;
				emit_hit = hit_q;
			end
			default: ;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rwc_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// request capture, address and limit computed on acceptance
	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_q <= req_type;
			row_q      <= row;
			col_q      <= col;
			value_q    <= value;
			addr_q     <= LW'(row) * LW'(dim) + LW'(col);
			limit_q    <= LW'(dim) * LW'(dim);
			in_range_q <= (RCW'(row) < RCW'(dim)) && (RCW'(col) < RCW'(dim));
		end
		if (state_q == rwc_pkg::ST_LOOKUP) begin
			hit_q <= acc_hit;
		end
	end

	// window tag, dirty flag, fill counter and pending write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_valid_q <= 1'b0;
			win_dirty_q <= 1'b0;
			win_row_q   <= '0;
			win_col_q   <= '0;
			win_base_q  <= '0;
			win_cnt_q   <= '0;
			fill_cnt_q  <= '0;
			wb_pend_q   <= 1'b0;
			wb_only_q   <= 1'b0;
		end else begin
			if (state_q == rwc_pkg::ST_IDLE && wb_pend_q) begin
				wb_pend_q <= 1'b0;
				wb_only_q <= 1'b1;
			end else if (state_q == rwc_pkg::ST_LOOKUP) begin
				wb_only_q <= 1'b0;
			end
			if (fill_go) begin
				win_valid_q <= 1'b1;
				win_dirty_q <= 1'b0;
				win_row_q   <= is_reset ? '0 : row_q;
				win_col_q   <= is_reset ? '0 : col_q;
				win_base_q  <= base_new;
				win_cnt_q   <= (rem < LW'(width)) ? CW'(rem) : width;
				if (is_reset) begin
					fill_cnt_q <= rwc_pkg::COUNT_BITS'(1);
				end else if (fill_cnt_q != '1) begin
					fill_cnt_q <= fill_cnt_q + 1'b1;
				end
			end
			if (wb_we && (state_q == rwc_pkg::ST_LOOKUP || state_q == rwc_pkg::ST_ACCESS)
				&& !is_load) begin
				win_dirty_q <= 1'b1;
			end
			// a register write flushes and drops the window
			if (cfg_wr) begin
				win_valid_q <= 1'b0;
				win_dirty_q <= 1'b0;
				if (need_wb) begin
					wb_pend_q <= 1'b1;
				end
			end
		end
	end

	// sweep counter and memory pipeline stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			pipe_vld_s1 <= 1'b0;
		end else begin
			if (sweep_go) begin
				idx_q <= '0;
			end else if (wb_issue || fill_issue) begin
				idx_q <= idx_q + 1'b1;
			end
			pipe_vld_s1 <= wb_issue || fill_issue;
		end
	end

	always_ff @(posedge clk) begin
		pipe_idx_s1  <= idx_q[IW-1:0];
		pipe_zero_s1 <= (sweep_addr >= limit_q);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rdata_q   <= emit_rd;
			hit_out_q <= emit_hit;
			miss_q    <= fill_cnt_q;
		end
	end

	assign done       = done_q;
	assign read_data  = rdata_q;
	assign hit        = hit_out_q;
	assign miss_count = miss_q;

	assign status.state    = state_q;
	assign status.wb_pend  = wb_pend_q;
	assign status.pipe_vld = pipe_vld_s1;

	// backing store
	rwc_ram #(
		.WIDTH (DATA_BITS),
		.DEPTH (DIM_MAX * DIM_MAX)
	) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	// window buffer
	rwc_ram #(
		.WIDTH (DATA_BITS),
		.DEPTH (WINDOW_MAX)
	) u_window (
		.clk   (clk),
		.we    (wb_we),
		.waddr (wb_waddr),
		.wdata (wb_wdata),
		.raddr (wb_raddr),
		.rdata (wb_rdata)
	);

endmodule

// ===== src/row_window_write_back_cache_top.sv =====
// ----------------------------------------------------------------------------
// row_window_write_back_cache_top
// Single window write-back cache in front of a row-major square matrix store.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result appears on
// read_data, hit and miss_count for exactly one cycle with done high and must
// be captured then, as there is no way to hold it. A load, a write hit or a
// request outside the matrix passes through the lookup state only, a read hit
// through the lookup and read-out states. A miss or reset request goes through
// the window buffer and store ports one word per cycle: a refill sweep of
// window_width words, preceded by a write-back sweep of the words in the old
// window when the old window is dirty. A register write with a dirty window
// flushes it the same way, holding busy high for that time. Both memories
// have one read and one write port with a registered read.
// ----------------------------------------------------------------------------
module row_window_write_back_cache_top #(
	parameter int unsigned DATA_BITS  = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// request channel
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        req_type,
	input  logic [rwc_pkg::POS_BITS-1:0]      row,
	input  logic [rwc_pkg::POS_BITS-1:0]      col,
	input  logic [DATA_BITS-1:0]              value,
	// result channel
	output logic                              done,
	output logic [DATA_BITS-1:0]              read_data,
	output logic                              hit,
	output logic [rwc_pkg::COUNT_BITS-1:0]    miss_count,
	// configuration port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [rwc_pkg::PADDR_BITS-1:0]    paddr,
	input  logic [rwc_pkg::PDATA_BITS-1:0]    pwdata,
	output logic [rwc_pkg::PDATA_BITS-1:0]    prdata,
	output logic                              pready
);

	logic [rwc_pkg::DIM_W-1:0] dim;
	logic [rwc_pkg::CW-1:0]    width;
	logic                      cfg_wr;
	rwc_pkg::seq_status_t      status;

	// configuration registers
	rwc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.dim     (dim),
		.width   (width),
		.cfg_wr  (cfg_wr)
	);

	// request sequencer with its memories
	rwc_seq #(
		.DATA_BITS  (DATA_BITS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.row        (row),
		.col        (col),
		.value      (value),
		.dim        (dim),
		.width      (width),
		.cfg_wr     (cfg_wr),
		.done       (done),
		.read_data  (read_data),
		.hit        (hit),
		.miss_count (miss_count),
		.status     (status)
	);

	// an accepted transfer always makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after an accepted transfer");

	// results never come in consecutive cycles
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe high in two consecutive cycles");

	// a pending flush keeps requests out
	a_pend_busy: assert property (@(posedge clk) disable iff (!arst_n)
		status.wb_pend |-> busy)
		else $error("flush pending while not busy");

	// sweeps drain their memory stage before going idle
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(status.state == rwc_pkg::ST_IDLE) |-> !status.pipe_vld)
		else $error("memory stage still active in idle");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the row window write-back cache. A behavioural copy
// of the cache (store, window, tag, dirty flag, fill counter) predicts every
// result as each request transfer is accepted; a monitor compares each done
// strobe with the oldest prediction. Directed checks come first, then random
// traffic over several register settings, with random gaps on the request side.
// ----------------------------------------------------------------------------
module testbench;

	localparam int unsigned DIM_MAX     = rwc_pkg::DIM_MAX;
	localparam int unsigned WINDOW_MAX  = rwc_pkg::WINDOW_MAX;
	localparam int unsigned DATA_BITS   = 32;
	localparam int unsigned STORE_WORDS = DIM_MAX * DIM_MAX;

	typedef struct packed {
		logic [DATA_BITS-1:0]           read_data;
		logic                           hit;
		logic [rwc_pkg::COUNT_BITS-1:0] miss_count;
	} cache_reply_t;

	// dut signals
	logic                             clk     = 1'b0;
	logic                             arst_n  = 1'b0;
	logic                             start   = 1'b0;
	logic                             busy;
	logic [1:0]                       req_type = rwc_pkg::REQ_LOAD;
	logic [rwc_pkg::POS_BITS-1:0]     row     = '0;
	logic [rwc_pkg::POS_BITS-1:0]     col     = '0;
	logic [DATA_BITS-1:0]             value   = '0;
	logic                             done;
	logic [DATA_BITS-1:0]             read_data;
	logic                             hit;
	logic [rwc_pkg::COUNT_BITS-1:0]   miss_count;
	logic                             psel    = 1'b0;
	logic                             penable = 1'b0;
	logic                             pwrite  = 1'b0;
	logic [rwc_pkg::PADDR_BITS-1:0]   paddr   = '0;
	logic [rwc_pkg::PDATA_BITS-1:0]   pwdata  = '0;
	logic [rwc_pkg::PDATA_BITS-1:0]   prdata;
	logic                             pready;

	// predicted cache state
	logic [DATA_BITS-1:0]             store_words [STORE_WORDS];
	bit                               store_known [STORE_WORDS];
	logic [DATA_BITS-1:0]             win_words [WINDOW_MAX];
	int unsigned                      win_row_q;
	int unsigned                      win_col_q;
	bit                               win_valid_q;
	bit                               win_dirty_q;
	logic [rwc_pkg::COUNT_BITS-1:0]   fill_count;
	logic [rwc_pkg::MD_BITS-1:0]      dim_reg;
	logic [rwc_pkg::WW_BITS-1:0]      width_reg;

	cache_reply_t            expected_replies [$];
	int unsigned             sent_count;
	int unsigned             mismatches;
	bit                      idle_disabled;

	row_window_write_back_cache_top #(
		.DATA_BITS  (DATA_BITS)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.row        (row),
		.col        (col),
		.value      (value),
		.done       (done),
		.read_data  (read_data),
		.hit        (hit),
		.miss_count (miss_count),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	// clock
	always #4 clk = ~clk;

	// ------------------------------------------------------------------------
	// behavioural cache
	// ------------------------------------------------------------------------

	// register values as used, clamped to the legal range
	function automatic int unsigned eff_dim();
		if (dim_reg == 0) return 1;
		if (dim_reg > DIM_MAX) return DIM_MAX;
		return dim_reg;
	endfunction

	function automatic int unsigned eff_width();
		if (width_reg == 0) return 1;
		if (width_reg > WINDOW_MAX) return WINDOW_MAX;
		return width_reg;
	endfunction

	function automatic bit window_holds(int unsigned r, int unsigned c);
		return win_valid_q && r == win_row_q && c >= win_col_q &&
			(c - win_col_q) < eff_width();
	endfunction

	// dirty window back to the store, words past the matrix end are dropped
	function automatic void flush_window();
		int unsigned d;
		int unsigned base;
		d = eff_dim();
		base = win_row_q * d + win_col_q;
		if (win_valid_q && win_dirty_q)
			for (int unsigned i = 0; i < eff_width(); i++)
				if (base + i < d * d) begin
					store_words[base + i] = win_words[i];
					store_known[base + i] = 1'b1;
				end
		win_dirty_q = 1'b0;
	endfunction

	// new window from (r, c), words past the matrix end read as zero
	function automatic void refill_window(int unsigned r, int unsigned c);
		int unsigned d;
		int unsigned a;
		d = eff_dim();
		win_row_q = r;
		win_col_q = c;
		for (int unsigned i = 0; i < eff_width(); i++) begin
			a = r * d + c + i;
			win_words[i] = (a < d * d) ? store_words[a] : '0;
		end
		win_valid_q = 1'b1;
		win_dirty_q = 1'b0;
		if (fill_count != '1) fill_count++;
	endfunction

	// result of one request, updating the predicted state
	function automatic cache_reply_t compute_reply(logic [1:0] kind, int unsigned r,
		int unsigned c, logic [DATA_BITS-1:0] v);
		cache_reply_t reply;
		int unsigned d;
		int unsigned w;
		int unsigned addr;
		int unsigned base;
		int unsigned off;
		reply = '0;
		d = eff_dim();
		w = eff_width();
		if (kind == rwc_pkg::REQ_RESET) begin
			flush_window();
			fill_count = '0;
			refill_window(0, 0);
		end else if (r < d && c < d) begin
			addr = r * d + c;
			if (kind == rwc_pkg::REQ_LOAD) begin
				store_words[addr] = v;
				store_known[addr] = 1'b1;
				// keep the window coherent with the store
				if (win_valid_q) begin
					base = win_row_q * d + win_col_q;
					if (addr >= base && addr - base < w) win_words[addr - base] = v;
				end
			end else begin
				if (window_holds(r, c)) begin
					reply.hit = 1'b1;
					off = c - win_col_q;
				end else begin
					flush_window();
					refill_window(r, c);
					off = 0;
				end
				if (kind == rwc_pkg::REQ_READ) reply.read_data = win_words[off];
				else begin
					win_words[off] = v;
					win_dirty_q = 1'b1;
				end
			end
		end
		reply.miss_count = fill_count;
		return reply;
	endfunction

	// ------------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------------

	task automatic report_mismatch(string msg);
		mismatches++;
		$display("%0t ns: mismatch: %s", $time, msg);
	endtask

	// compare each result transfer with the oldest prediction
	always @(posedge clk) begin : check_replies
		cache_reply_t want;
		if (arst_n && done) begin
			if (expected_replies.size() == 0) report_mismatch("result with none expected");
			else begin
				want = expected_replies.pop_front();
				if (read_data !== want.read_data)
					report_mismatch($sformatf("read_data %h, expected %h",
						read_data, want.read_data));
				if (hit !== want.hit)
					report_mismatch($sformatf("hit %b, expected %b", hit, want.hit));
				if (miss_count !== want.miss_count)
					report_mismatch($sformatf("miss_count %0d, expected %0d",
						miss_count, want.miss_count));
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------

	// mostly back to back or short gaps, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned roll;
		if (idle_disabled) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [DATA_BITS-1:0] random_word();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return '0;
			3: return '1;
			default: return $urandom();
		endcase
	endfunction

	// one request transfer; start stays high when the next follows at once
	task automatic send_request(logic [1:0] kind, int unsigned r, int unsigned c,
		logic [DATA_BITS-1:0] v);
		int unsigned gap;
		req_type <= kind;
		row <= r[rwc_pkg::POS_BITS-1:0];
		col <= c[rwc_pkg::POS_BITS-1:0];
		value <= v;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		expected_replies.push_back(compute_reply(kind, r, c, v));
		sent_count++;
		gap = pick_gap();
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// load every store word a refill would read that was never written
	task automatic request(logic [1:0] kind, int unsigned r, int unsigned c,
		logic [DATA_BITS-1:0] v);
		int unsigned d;
		int unsigned base;
		int unsigned a;
		d = eff_dim();
		if (kind == rwc_pkg::REQ_RESET || (kind != rwc_pkg::REQ_LOAD && r < d && c < d
			&& !window_holds(r, c))) begin
			base = (kind == rwc_pkg::REQ_RESET) ? 0 : r * d + c;
			for (int unsigned i = 0; i < eff_width(); i++) begin
				a = base + i;
				if (a < d * d && !store_known[a])
					send_request(rwc_pkg::REQ_LOAD, a / d, a % d, random_word());
			end
		end
		send_request(kind, r, c, v);
	endtask

	// drop start and wait for every predicted result
	task automatic settle_results();
		start <= 1'b0;
		@(posedge clk);
		while (expected_replies.size() != 0) @(posedge clk);
	endtask

	// register write on the apb port, only with the cache idle
	task automatic write_register(logic idx, logic [rwc_pkg::PDATA_BITS-1:0] data);
		settle_results();
		while (busy) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		// the cache flushes a dirty window with the old settings, then invalidates
		flush_window();
		win_valid_q = 1'b0;
		if (idx == rwc_pkg::REG_MATRIX_DIM) dim_reg = data[rwc_pkg::MD_BITS-1:0];
		else width_reg = data[rwc_pkg::WW_BITS-1:0];
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic configure(int unsigned dim_val, int unsigned width_val);
		write_register(rwc_pkg::REG_MATRIX_DIM, dim_val);
		write_register(rwc_pkg::REG_WINDOW_WIDTH, width_val);
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// hits, misses, write-back, coherent loads, window past the end, reset request
	task automatic test_window_basics();
		request(rwc_pkg::REQ_READ, 0, 0, '0);
		request(rwc_pkg::REQ_READ, 0, 3, '0);
		request(rwc_pkg::REQ_WRITE, 0, 3, 32'h7fff_ffff);
		request(rwc_pkg::REQ_WRITE, 0, 1, 32'h8000_0000);
		request(rwc_pkg::REQ_READ, 1, 0, '0);
		request(rwc_pkg::REQ_READ, 0, 1, '0);
		request(rwc_pkg::REQ_LOAD, 0, 2, '1);
		request(rwc_pkg::REQ_READ, 0, 2, '0);
		request(rwc_pkg::REQ_READ, 63, 62, '0);
		request(rwc_pkg::REQ_WRITE, 63, 63, '0);
		request(rwc_pkg::REQ_READ, 63, 63, '0);
		request(rwc_pkg::REQ_RESET, 0, 0, '0);
		request(rwc_pkg::REQ_READ, 0, 0, '0);
	endtask

	// requests outside a small matrix do nothing, then its last word is read and written
	task automatic test_out_of_range();
		configure(5, 3);
		request(rwc_pkg::REQ_READ, 5, 0, '0);
		request(rwc_pkg::REQ_WRITE, 0, 63, 32'h1234_5678);
		request(rwc_pkg::REQ_LOAD, 63, 63, '1);
		request(rwc_pkg::REQ_READ, 4, 4, '0);
		request(rwc_pkg::REQ_WRITE, 4, 4, 32'h8000_0000);
		request(rwc_pkg::REQ_READ, 4, 4, '0);
	endtask

	// random traffic at one register setting, biased towards the window
	task automatic random_phase(int unsigned dim_val, int unsigned width_val,
		int unsigned n, bit idle_off);
		int unsigned target;
		int unsigned d;
		int unsigned w;
		int unsigned r;
		int unsigned c;
		int unsigned tmp;
		int unsigned roll;
		logic [1:0] kind;
		configure(dim_val, width_val);
		idle_disabled = idle_off;
		d = eff_dim();
		w = eff_width();
		target = sent_count + n;
		while (sent_count < target) begin
			roll = $urandom_range(0, 99);
			if (roll < 42) kind = rwc_pkg::REQ_READ;
			else if (roll < 80) kind = rwc_pkg::REQ_WRITE;
			else if (roll < 96) kind = rwc_pkg::REQ_LOAD;
			else kind = rwc_pkg::REQ_RESET;
			roll = $urandom_range(0, 99);
			if (roll < 55 && win_valid_q) begin
				// in or just past the current window
				r = win_row_q;
				c = win_col_q + $urandom_range(0, w);
				if (c >= d) c = d - 1;
			end else if (roll < 65 && d < DIM_MAX) begin
				r = $urandom_range(0, 63);
				c = $urandom_range(d, 63);
				if ($urandom_range(0, 1)) begin
					tmp = r;
					r = c;
					c = tmp;
				end
			end else begin
				// large matrices mostly touch a few rows to keep the loads down
				if (d > 16 && $urandom_range(0, 99) < 85)
					case ($urandom_range(0, 3))
						0: r = 0;
						1: r = 1;
						2: r = d / 2;
						default: r = d - 1;
					endcase
				else r = $urandom_range(0, d - 1);
				c = $urandom_range(0, d - 1);
			end
			request(kind, r, c, random_word());
		end
		idle_disabled = 1'b0;
	endtask

	task automatic test_random_traffic();
		random_phase(8, 4, 260, 1'b0);
		random_phase(64, 16, 260, 1'b0);
		random_phase(1, 1, 100, 1'b1);
		random_phase(3, 16, 150, 1'b0);
		random_phase(64, 1, 200, 1'b0);
		random_phase(20, 5, 250, 1'b1);
		random_phase(0, 31, 100, 1'b0);
		random_phase(127, 0, 100, 1'b0);
		random_phase(13, 7, 200, 1'b0);
		random_phase(64, 4, 200, 1'b0);
	endtask

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------

	initial begin
		dim_reg = rwc_pkg::MD_RESET;
		width_reg = rwc_pkg::WW_RESET;
		win_row_q = 0;
		win_col_q = 0;
		win_valid_q = 1'b0;
		win_dirty_q = 1'b0;
		fill_count = '0;
		sent_count = 0;
		mismatches = 0;
		idle_disabled = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_window_basics();
		test_out_of_range();
		test_random_traffic();
		settle_results();
		repeat (60) @(posedge clk);
		if (mismatches == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end

	// run limit
	initial begin
		#10_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
